FILE: rtl/mrs_pkg.sv
// shared types and constants for the modem reply scanner
package mrs_pkg;

    typedef logic [7:0] t_byte;

    // pattern matches on the five-byte window of recent bytes
    typedef struct packed {
        logic tx_ok;
        logic ok;
        logic otaa;
        logic at_error;
    } t_win_hits;

    localparam int WIN_DEPTH = 5;

    // item kinds carried on the input tuser bit
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // characters the scanner looks for
    localparam t_byte CH_GT    = 8'h3E;  // '>'
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_LO_T  = 8'h74;  // 't'
    localparam t_byte CH_LO_X  = 8'h78;  // 'x'
    localparam t_byte CH_LO_O  = 8'h6F;  // 'o'
    localparam t_byte CH_LO_K  = 8'h6B;  // 'k'
    localparam t_byte CH_O     = 8'h4F;
    localparam t_byte CH_K     = 8'h4B;
    localparam t_byte CH_T     = 8'h54;
    localparam t_byte CH_A     = 8'h41;
    localparam t_byte CH_E     = 8'h45;
    localparam t_byte CH_R     = 8'h52;
    localparam t_byte CH_I     = 8'h49;
    localparam t_byte CH_D     = 8'h44;
    localparam t_byte CH_UNDER = 8'h5F;  // '_'

    // frame index at which a reply frame is complete
    localparam int REPLY_LEN = 17;

    // frame store positions that the pattern checks read; only these are kept
    localparam int KEEP_N = 7;
    localparam int SLOT_P2  = 0;
    localparam int SLOT_P3  = 1;
    localparam int SLOT_P4  = 2;
    localparam int SLOT_P5  = 3;
    localparam int SLOT_P6  = 4;
    localparam int SLOT_P7  = 5;
    localparam int SLOT_P14 = 6;
    localparam int KEEP_POS [KEEP_N] = '{2, 3, 4, 5, 6, 7, 14};

    // result tdata layout, lowest bit first
    localparam int OUT_BITS  = 61;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
    localparam int POS_BITS  = 7;
    localparam int TOTAL_BITS = 16;

endpackage

FILE: rtl/mrs_window.sv
// five-byte window of recent bytes and its fixed pattern matches
module mrs_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  mrs_pkg::t_byte    i_byte,
    output mrs_pkg::t_win_hits o_hits
);

    mrs_pkg::t_byte r_win [mrs_pkg::WIN_DEPTH];
    mrs_pkg::t_byte n_win [mrs_pkg::WIN_DEPTH];

    // entry 4 is the newest byte
    always_comb begin
        for (int i = 0; i < mrs_pkg::WIN_DEPTH - 1; i++) begin
            n_win[i] = r_win[i + 1];
        end
        n_win[mrs_pkg::WIN_DEPTH - 1] = i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mrs_pkg::WIN_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_step) begin
            r_win <= n_win;
        end
    end

    // matches are taken on the window after the shift; middle of tx pattern is a wildcard
    always_comb begin
        o_hits.tx_ok    = (n_win[0] == mrs_pkg::CH_LO_T) && (n_win[1] == mrs_pkg::CH_LO_X) &&
                          (n_win[3] == mrs_pkg::CH_LO_O) && (n_win[4] == mrs_pkg::CH_LO_K);
        o_hits.ok       = (n_win[1] == mrs_pkg::CH_CR) && (n_win[2] == mrs_pkg::CH_LF) &&
                          (n_win[3] == mrs_pkg::CH_O) && (n_win[4] == mrs_pkg::CH_K);
        o_hits.otaa     = (n_win[1] == mrs_pkg::CH_O) && (n_win[2] == mrs_pkg::CH_T) &&
                          (n_win[3] == mrs_pkg::CH_A) && (n_win[4] == mrs_pkg::CH_A);
        o_hits.at_error = (n_win[0] == mrs_pkg::CH_A) && (n_win[1] == mrs_pkg::CH_T) &&
                          (n_win[2] == mrs_pkg::CH_UNDER) && (n_win[3] == mrs_pkg::CH_E) &&
                          (n_win[4] == mrs_pkg::CH_R);
    end

endmodule

FILE: rtl/mrs_frame.sv
// frame index, byte total and the frame store positions that the checks read
module mrs_frame #(
    parameter int FRAME_BYTES = 64,
    parameter int IDX_BITS    = $clog2(FRAME_BYTES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_clear,
    input  mrs_pkg::t_byte                i_byte,
    output logic                          o_reply_hit,
    output logic                          o_id_hit,
    output logic [31:0]                   o_id_value,
    output logic [IDX_BITS-1:0]           o_index,
    output logic [mrs_pkg::TOTAL_BITS-1:0] o_total
);

    mrs_pkg::t_byte r_keep [mrs_pkg::KEEP_N];
    mrs_pkg::t_byte n_keep [mrs_pkg::KEEP_N];
    logic [IDX_BITS-1:0]            r_index;
    logic [IDX_BITS-1:0]            n_index;
    logic [mrs_pkg::TOTAL_BITS-1:0] r_total;
    logic [mrs_pkg::TOTAL_BITS-1:0] n_total;
    logic [IDX_BITS-1:0]            w_idx_eff;
    logic                           w_write;

    // '>' restarts the frame before the byte is stored
    assign w_idx_eff = (i_byte == mrs_pkg::CH_GT) ? '0 : r_index;
    assign w_write   = (w_idx_eff < IDX_BITS'(FRAME_BYTES));

    always_comb begin
        for (int k = 0; k < mrs_pkg::KEEP_N; k++) begin
            if (i_clear) begin
                n_keep[k] = mrs_pkg::CH_SPACE;
            end else if (w_write && (w_idx_eff == IDX_BITS'(mrs_pkg::KEEP_POS[k]))) begin
                n_keep[k] = i_byte;
            end else begin
                n_keep[k] = r_keep[k];
            end
        end
        if (i_clear) begin
            n_index = '0;
            n_total = '0;
        end else begin
            n_index = w_write ? w_idx_eff + 1'b1 : w_idx_eff;
            n_total = r_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mrs_pkg::KEEP_N; k++) begin
                r_keep[k] <= mrs_pkg::CH_SPACE;
            end
            r_index <= '0;
            r_total <= '0;
        end else if (i_step) begin
            r_keep  <= n_keep;
            r_index <= n_index;
            r_total <= n_total;
        end
    end

    // checks read the store after this byte is written
    assign o_reply_hit = !i_clear && (n_index == IDX_BITS'(mrs_pkg::REPLY_LEN)) &&
                         (n_keep[mrs_pkg::SLOT_P2] == mrs_pkg::CH_E) &&
                         (n_keep[mrs_pkg::SLOT_P3] == mrs_pkg::CH_A) &&
                         (n_keep[mrs_pkg::SLOT_P14] == mrs_pkg::CH_E);
    assign o_id_hit    = !i_clear && (n_keep[mrs_pkg::SLOT_P2] == mrs_pkg::CH_I) &&
                         (n_keep[mrs_pkg::SLOT_P7] == mrs_pkg::CH_D);
    assign o_id_value  = o_id_hit ? {n_keep[mrs_pkg::SLOT_P3], n_keep[mrs_pkg::SLOT_P4],
                                     n_keep[mrs_pkg::SLOT_P5], n_keep[mrs_pkg::SLOT_P6]}
                                  : '0;
    assign o_index     = n_index;
    assign o_total     = n_total;

endmodule

FILE: rtl/modem_reply_scanner_unit.sv
// top level of the modem reply scanner: input register, scan logic, result register
//
// Scans a stream of received modem bytes and returns one result transaction per
// input transaction, in order. An input with tuser = 0 is a received byte: it bumps
// a wrapping 16-bit byte total, shifts into a five-byte window and, while the frame
// index is below FRAME_BYTES, is written to the frame store at that index ('>' first
// restarts the index). The result flags the window patterns "tx?ok", CR LF "OK",
// "OTAA" and "AT_ER", a 17-byte reply frame with 'E','A' at positions 2,3 and 'E' at
// 14, and an identifier ('I' at 2, 'D' at 7) with the four bytes at positions 3..6.
// An input with tuser = 1 refills the store with spaces and zeroes index and total;
// its result carries all zeros and the window is kept. Only the store positions the
// checks read are held in flip-flops, so there is no memory and no clearing pass.
// Throughput is one transaction per clock while results are taken: the byte sits in
// the input register, the compares on the next window and store state are
// combinational, and the result register holds the answer; a stalled result keeps
// the next item waiting in the input register. The input side stays ready while the
// result register drains.
module modem_reply_scanner_unit #(
    parameter int FRAME_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] tx_ok_hit, [1] ok_hit, [2] otaa_hit, [3] at_error_hit, [4] reply_frame_hit,
    // [5] id_hit, [37:6] id_value, [44:38] frame_position, [60:45] bytes_seen, rest zero
    output logic [mrs_pkg::OUT_BYTES*8-1:0] o_m_tdata
);

    localparam int IDX_BITS = $clog2(FRAME_BYTES + 1);
    localparam int OUT_W    = mrs_pkg::OUT_BYTES * 8;

    // input register
    logic           r_in_valid;
    logic           r_in_kind;
    mrs_pkg::t_byte r_in_byte;

    // result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    // advance: item in the input register moves into the result register
    logic w_move;

    mrs_pkg::t_win_hits                 w_hits;
    logic                               w_reply;
    logic                               w_id_hit;
    logic [31:0]                        w_id_value;
    logic [IDX_BITS-1:0]                w_index;
    logic [mrs_pkg::TOTAL_BITS-1:0]     w_total;
    logic [IDX_BITS+mrs_pkg::POS_BITS-1:0] w_index_ext;
    logic [mrs_pkg::POS_BITS-1:0]       w_position;
    logic                               w_clear;
    logic [OUT_W-1:0]                   w_packed;

    assign w_move     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_move;
    assign w_clear    = (r_in_kind == mrs_pkg::KIND_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_kind <= i_s_tuser;
            r_in_byte <= i_s_tdata;
        end
    end

    mrs_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_move && !w_clear),
        .i_byte  (r_in_byte),
        .o_hits  (w_hits)
    );

    mrs_frame #(
        .FRAME_BYTES (FRAME_BYTES),
        .IDX_BITS    (IDX_BITS)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_move),
        .i_clear     (w_clear),
        .i_byte      (r_in_byte),
        .o_reply_hit (w_reply),
        .o_id_hit    (w_id_hit),
        .o_id_value  (w_id_value),
        .o_index     (w_index),
        .o_total     (w_total)
    );

    // frame position carries the low seven bits of the index
    assign w_index_ext = {{mrs_pkg::POS_BITS{1'b0}}, w_index};
    assign w_position  = w_index_ext[mrs_pkg::POS_BITS-1:0];

    // window hits are zero on a clear transaction
    assign w_packed = {{(OUT_W - mrs_pkg::OUT_BITS){1'b0}},
                       w_total,
                       w_position,
                       w_id_value,
                       w_id_hit,
                       w_reply,
                       w_hits.at_error && !w_clear,
                       w_hits.otaa && !w_clear,
                       w_hits.ok && !w_clear,
                       w_hits.tx_ok && !w_clear};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_data <= w_packed;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: rtl/mrs_checker.sv
// port-level checks for the modem reply scanner, bound to the top level
module mrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata
);

    // a stalled result transaction holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // identifier bytes are zero unless the identifier is flagged
    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[5] |-> o_m_tdata[37:6] == 32'd0)
        else $error("id value set without id hit");

    // a reply frame is flagged only at frame position 17
    a_reply_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[4] |-> o_m_tdata[44:38] == 7'd17)
        else $error("reply hit at wrong frame position");

    // the ok and otaa hits, and the tx_ok and at_error hits, disagree on a byte and never fire together
    a_win_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[1] && o_m_tdata[2]) && !(o_m_tdata[0] && o_m_tdata[3]))
        else $error("conflicting window hits");

    // unused top bits of the result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[63:61] == 3'd0)
        else $error("result padding not zero");

endmodule

bind modem_reply_scanner_unit mrs_checker u_mrs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
